// ===== src/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int unsigned DEPTH     = 32;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_DELETE   = 3'd2,
    CMD_SEARCH   = 3'd3,
    CMD_TRAVERSE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_TRAVERSE
  } state_e;

  // Per-cell load select.
  typedef struct packed {
    logic load_val;
    logic take_prev;
    logic take_next;
  } cell_ctrl_t;

endpackage

// ===== src/ple_cell.sv =====
// One list cell: holds an entry, shifts to or from its neighbors and compares a key.
module ple_cell (
  input  logic              clk_i,
  input  ple_pkg::cell_ctrl_t ctrl_i,
  input  ple_pkg::word_t    value_i,
  input  ple_pkg::word_t    prev_i,
  input  ple_pkg::word_t    next_i,
  output ple_pkg::word_t    data_o,
  output logic              match_o
);

  ple_pkg::word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load_val) begin
      data_d = value_i;
    end else if (ctrl_i.take_prev) begin
      data_d = prev_i;
    end else if (ctrl_i.take_next) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == value_i);

endmodule

// ===== src/positional_list_engine.sv =====
// Top level of the positional list engine: cell chain, command sequencer, result register.
// Clear, insert and delete act on accept; their result is registered and seen the next cycle.
// Search: every cell compares at once into match_q, then S_SEARCH encodes the first match.
// Traverse streams one entry per cycle unless the output stalls (one beat for empty).
// A new command is taken only when the sequencer is idle and the result register is free.
// Reset (rst_ni low, asynchronous) empties the list; entry contents are not cleared.
module positional_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic signed [31:0] value_i,
  input  logic [5:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [5:0]  found_position_o,
  output logic signed [31:0] element_o,
  output logic [5:0]  entry_count_o,
  output logic        last_o
);

  localparam int unsigned D  = ple_pkg::DEPTH;
  localparam int unsigned IW = ple_pkg::IDX_W;
  localparam int unsigned CW = ple_pkg::CNT_W;

  ple_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [D-1:0]    match_q, match_d, match_raw;

  ple_pkg::word_t     cell_data [D];
  ple_pkg::cell_ctrl_t cell_ctrl [D];
  ple_pkg::word_t     key;

  logic out_valid_q;
  logic [2:0]  status_q, status_d;
  logic [5:0]  found_q, found_d;
  logic [31:0] element_q, element_d;
  logic [5:0]  ecount_q, ecount_d;
  logic        last_q, last_d;
  logic        out_load, out_free, in_accept;

  logic [CW:0] count_p1;
  logic        ins_ok_pos, del_ok_pos, not_full;
  logic        hit;
  logic [IW-1:0] first_idx;

  assign key = ple_pkg::word_t'(value_i);

  // Cell chain.
  for (genvar i = 0; i < D; i++) begin : g_cell
    ple_pkg::word_t prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_p
      assign prev_w = cell_data[i-1];
    end
    if (i == D - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_n
      assign next_w = cell_data[i+1];
    end
    ple_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .value_i (key),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .data_o  (cell_data[i]),
      .match_o (match_raw[i])
    );
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ple_pkg::S_IDLE) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign count_p1   = {1'b0, count_q} + 1'b1;
  assign ins_ok_pos = (position_i != '0) && ({1'b0, position_i} <= count_p1);
  assign del_ok_pos = (position_i != '0) && ({1'b0, position_i} <= {1'b0, count_q});
  assign not_full   = (count_q < CW'(D));

  // First match, lowest index wins.
  always_comb begin
    first_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first_idx = IW'(i);
      end
    end
  end
  assign hit = |match_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    match_d   = match_q;
    out_load  = 1'b0;
    status_d  = ple_pkg::ST_OK;
    found_d   = '0;
    element_d = '0;
    ecount_d  = 6'(count_q);
    last_d    = 1'b1;
    for (int i = 0; i < D; i++) begin
      cell_ctrl[i] = '0;
    end

    case (state_q)
      ple_pkg::S_IDLE: begin
        if (in_accept) begin
          case (cmd_i)
            ple_pkg::CMD_CLEAR: begin
              count_d  = '0;
              ecount_d = '0;
              out_load = 1'b1;
            end
            ple_pkg::CMD_INSERT: begin
              out_load = 1'b1;
              if (!ins_ok_pos) begin
                status_d = ple_pkg::ST_BAD_POS;
              end else if (!not_full) begin
                status_d = ple_pkg::ST_FULL;
              end else begin
                count_d  = CW'(count_p1);
                ecount_d = 6'(count_p1);
                for (int i = 0; i < D; i++) begin
                  cell_ctrl[i].load_val  = (7'(i) + 7'd1 == {1'b0, position_i});
                  cell_ctrl[i].take_prev = (7'(i) >= {1'b0, position_i});
                end
              end
            end
            ple_pkg::CMD_DELETE: begin
              out_load = 1'b1;
              if (!del_ok_pos) begin
                status_d = ple_pkg::ST_BAD_POS;
              end else begin
                count_d  = count_q - 1'b1;
                ecount_d = 6'(count_q - 1'b1);
                for (int i = 0; i < D; i++) begin
                  cell_ctrl[i].take_next = (7'(i) + 7'd1 >= {1'b0, position_i});
                end
              end
            end
            ple_pkg::CMD_SEARCH: begin
              for (int i = 0; i < D; i++) begin
                match_d[i] = match_raw[i] && (7'(i) < {1'b0, count_q});
              end
              state_d = ple_pkg::S_SEARCH;
            end
            ple_pkg::CMD_TRAVERSE: begin
              if (count_q == '0) begin
                status_d = ple_pkg::ST_EMPTY;
                out_load = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = ple_pkg::S_TRAVERSE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ple_pkg::S_SEARCH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (hit) begin
            found_d = 6'(first_idx) + 6'd1;
          end else begin
            status_d = ple_pkg::ST_NOT_FOUND;
          end
          state_d = ple_pkg::S_IDLE;
        end
      end
      ple_pkg::S_TRAVERSE: begin
        if (out_free) begin
          out_load  = 1'b1;
          element_d = 32'(signed'(cell_data[idx_q]));
          last_d    = ({1'b0, idx_q} + 1'b1 == CW'(count_q));
          idx_d     = idx_q + 1'b1;
          if (last_d) begin
            state_d = ple_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    match_q <= match_d;
    if (out_load) begin
      status_q  <= status_d;
      found_q   <= found_d;
      element_q <= element_d;
      ecount_q  <= ecount_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = found_q;
  assign element_o        = signed'(element_q);
  assign entry_count_o    = ecount_q;
  assign last_o           = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(D))
    else $error("entry count exceeds depth");

  a_trav_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ple_pkg::S_TRAVERSE) |-> ({1'b0, idx_q} < CW'(count_q)))
    else $error("traverse index beyond entry count");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ple_pkg::S_IDLE) |-> in_stall_o)
    else $error("command accepted while sequencer busy");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (cmd_i == ple_pkg::CMD_CLEAR)) |=> (count_q == '0))
    else $error("clear did not empty the list");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule

// ===== dv/tb_positional_list_engine.sv =====
// Self-checking testbench for the positional list engine with random input gaps and random output stalls.
module tb_positional_list_engine;

  localparam int unsigned RANDOM_ITEMS = 440;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD    = 150;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  found;
    logic [31:0] element;
    logic [5:0]  count;
    logic        last;
  } list_result_t;

  // Tracks the list contents and holds the beats the engine still owes.
  class list_scoreboard;
    ple_pkg::word_t cells[ple_pkg::DEPTH];
    int unsigned    fill;
    list_result_t   expected_beats[$];
    int unsigned    errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function void note_command(logic [2:0] cmd, ple_pkg::word_t value,
                               logic [5:0] position);
      int unsigned  pos;
      list_result_t r;
      pos    = 32'(position);
      r      = '0;
      r.last = 1'b1;
      case (cmd)
        ple_pkg::CMD_CLEAR: fill = 0;
        ple_pkg::CMD_INSERT: begin
          if (pos < 1 || pos > fill + 1) begin
            r.status = ple_pkg::ST_BAD_POS;
          end else if (fill >= ple_pkg::DEPTH) begin
            r.status = ple_pkg::ST_FULL;
          end else begin
            for (int unsigned i = fill; i >= pos; i--) cells[i] = cells[i-1];
            cells[pos-1] = value;
            fill++;
          end
        end
        ple_pkg::CMD_DELETE: begin
          if (pos < 1 || pos > fill) begin
            r.status = ple_pkg::ST_BAD_POS;
          end else begin
            for (int unsigned i = pos - 1; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        ple_pkg::CMD_SEARCH: begin
          r.status = ple_pkg::ST_NOT_FOUND;
          for (int unsigned i = 0; i < fill; i++) begin
            if (r.status == ple_pkg::ST_NOT_FOUND && cells[i] == value) begin
              r.status = ple_pkg::ST_OK;
              r.found  = 6'(i + 1);
            end
          end
        end
        ple_pkg::CMD_TRAVERSE: begin
          if (fill == 0) begin
            r.status = ple_pkg::ST_EMPTY;
          end else begin
            // A non-empty list streams one beat per entry; only the final one is marked.
            for (int unsigned i = 0; i < fill; i++) begin
              r.element = 32'(cells[i]);
              r.count   = 6'(fill);
              r.last    = (i + 1 == fill);
              expected_beats.push_back(r);
            end
            return;
          end
        end
        default: return;
      endcase
      r.count = 6'(fill);
      expected_beats.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: status %0d found %0d element %h count %0d last %0d",
                   got.status, got.found, got.element, got.count, got.last);
        return;
      end
      want = expected_beats.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.element !== want.element || got.count !== want.count ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $write("mismatch (expected/actual): status %0d/%0d found %0d/%0d",
                 want.status, got.status, want.found, got.found);
          $display(" element %h/%h count %0d/%0d last %0d/%0d",
                   want.element, got.element, want.count, got.count,
                   want.last, got.last);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         cmd_i;
  logic signed [31:0] value_i;
  logic [5:0]         position_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         status_o;
  logic [5:0]         found_position_o;
  logic signed [31:0] element_o;
  logic [5:0]         entry_count_o;
  logic               last_o;

  list_scoreboard sb;
  bit             quiet;
  int unsigned    rx_hold_len;
  int unsigned    items_sent;
  int unsigned    idle_cycles;

  positional_list_engine dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .element_o        (element_o),
    .entry_count_o    (entry_count_o),
    .last_o           (last_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic ple_pkg::word_t pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return ple_pkg::word_t'($urandom_range(1, 4));
      default: return ple_pkg::word_t'($urandom);
    endcase
  endfunction

  // The previous beat's valid is left high when no gap is drawn, so that back-to-back items follow without a gap.
  task automatic send_command(input logic [2:0] cmd, input ple_pkg::word_t value,
                              input logic [5:0] position);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= value;
    position_i <= position;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(cmd, value, position);
    if (cmd <= ple_pkg::CMD_TRAVERSE) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic build_list(input int unsigned length);
    send_command(ple_pkg::CMD_CLEAR, pick_value(), 6'($urandom_range(0, 63)));
    // Appends beyond DEPTH run into the full list.
    repeat (length) send_command(ple_pkg::CMD_INSERT, pick_value(), 6'(sb.fill + 1));
  endtask

  task automatic random_command();
    int unsigned    pick;
    ple_pkg::word_t key;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_command(ple_pkg::CMD_INSERT, pick_value(), 6'($urandom_range(1, sb.fill + 1)));
    end else if (pick < 50) begin
      if (sb.fill != 0)
        send_command(ple_pkg::CMD_DELETE, pick_value(), 6'($urandom_range(1, sb.fill)));
      else
        send_command(ple_pkg::CMD_DELETE, pick_value(), 6'($urandom_range(0, 63)));
    end else if (pick < 65) begin
      key = (sb.fill != 0) ? sb.cells[$urandom_range(0, sb.fill - 1)] : pick_value();
      send_command(ple_pkg::CMD_SEARCH, key, 6'($urandom_range(0, 63)));
    end else if (pick < 70) begin
      send_command(ple_pkg::CMD_SEARCH, pick_value(), 6'($urandom_range(0, 63)));
    end else if (pick < 78) begin
      send_command(ple_pkg::CMD_TRAVERSE, pick_value(), 6'($urandom_range(0, 63)));
    end else if (pick < 88) begin
      send_command(ple_pkg::CMD_INSERT, pick_value(), 6'($urandom_range(0, 63)));
    end else if (pick < 95) begin
      send_command(ple_pkg::CMD_DELETE, pick_value(), 6'($urandom_range(0, 63)));
    end else if (pick < 97) begin
      send_command(ple_pkg::CMD_CLEAR, pick_value(), 6'($urandom_range(0, 63)));
    end else begin
      send_command(3'($urandom_range(5, 7)), pick_value(), 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin : result_sink
    int unsigned pause;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len != 0) begin
        pause       = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        pause = quiet ? 0 : $urandom_range(0, 3);
      end
      if (pause != 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{status_o, found_position_o, element_o, entry_count_o, last_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL positional_list_engine");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned target;
    sb          = new();
    quiet       = 1'b0;
    rx_hold_len = 0;
    items_sent  = 0;
    idle_cycles = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    cmd_i       <= ple_pkg::CMD_CLEAR;
    value_i     <= '0;
    position_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-list corner cases first, then bad positions, extreme values, unknown commands and clear.
    send_command(ple_pkg::CMD_TRAVERSE, 32'h0, 6'd0);
    send_command(ple_pkg::CMD_SEARCH, 32'h0, 6'd0);
    send_command(ple_pkg::CMD_DELETE, 32'h0, 6'd1);
    send_command(ple_pkg::CMD_INSERT, 32'h1, 6'd0);
    send_command(ple_pkg::CMD_INSERT, 32'h1, 6'd2);
    send_command(ple_pkg::CMD_INSERT, 32'h7FFF_FFFF, 6'd1);
    send_command(ple_pkg::CMD_INSERT, 32'h8000_0000, 6'd2);
    send_command(ple_pkg::CMD_INSERT, 32'h0000_0000, 6'd1);
    send_command(ple_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd2);
    send_command(ple_pkg::CMD_INSERT, 32'h2, 6'd63);
    send_command(ple_pkg::CMD_SEARCH, 32'h8000_0000, 6'd0);
    send_command(ple_pkg::CMD_SEARCH, 32'h1234_5678, 6'd63);
    send_command(ple_pkg::CMD_TRAVERSE, 32'hFFFF_FFFF, 6'd63);
    send_command(ple_pkg::CMD_DELETE, 32'h0, 6'd63);
    send_command(ple_pkg::CMD_DELETE, 32'h0, 6'd0);
    send_command(ple_pkg::CMD_DELETE, 32'h0, 6'd2);
    send_command(ple_pkg::CMD_DELETE, 32'h0, 6'd3);
    send_command(3'd5, 32'hFFFF_FFFF, 6'd63);
    send_command(3'd6, 32'h0, 6'd1);
    send_command(3'd7, 32'h5555_5555, 6'd42);
    send_command(ple_pkg::CMD_SEARCH, 32'h0, 6'd21);
    send_command(ple_pkg::CMD_TRAVERSE, 32'h0, 6'd0);
    send_command(ple_pkg::CMD_CLEAR, 32'hAAAA_AAAA, 6'd63);
    send_command(ple_pkg::CMD_TRAVERSE, 32'h0, 6'd0);
    send_command(ple_pkg::CMD_INSERT, 32'h5A5A_5A5A, 6'd1);
    wait_drained();

    phase  = 0;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // Hold the output side while a full build is offered, so the input backs up.
        quiet       = 1'b1;
        rx_hold_len = LONG_HOLD;
        build_list(ple_pkg::DEPTH + 2);
      end else if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 2) == 0)
          build_list(ple_pkg::DEPTH + $urandom_range(0, 3));
        else
          build_list($urandom_range(1, 12));
      end else begin
        repeat ($urandom_range(8, 20)) random_command();
      end
      if (phase % 5 == 4) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS positional_list_engine");
    else
      $display("FAIL positional_list_engine");
    $finish;
  end

endmodule

// ===== files.f =====
src/ple_pkg.sv
src/ple_cell.sv
src/positional_list_engine.sv
dv/tb_positional_list_engine.sv
